// File: rtl/core/racodec_pkg.sv
package racodec_pkg;

   // Input item kinds, carried on req_tuser
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_RX    = 2'd2;

   // Result kinds, carried on rsp_tuser
   localparam logic KIND_TX   = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // Completion status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_HEADER   = 2'd1;
   localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

   // ASCII characters
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_R      = 8'h52;
   localparam logic [7:0] CH_W      = 8'h57;
   localparam logic [7:0] CH_C      = 8'h43;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;

   // Checksum seeds: command letter through "0x", and the ",0x" separator
   localparam logic [7:0] SEP_XOR      = CH_COMMA ^ CH_ZERO ^ CH_X;
   localparam logic [7:0] CMD_XOR_READ = CH_R ^ CH_C ^ SEP_XOR;
   localparam logic [7:0] CMD_XOR_WRITE = CH_W ^ CH_C ^ SEP_XOR;

   // Command frame layout (byte positions)
   localparam logic [4:0] POS_ADDR       = 5'd6;
   localparam logic [4:0] POS_ADDR_END   = 5'd14;
   localparam logic [4:0] POS_SEP_COMMA  = 5'd14;
   localparam logic [4:0] POS_SEP_ZERO   = 5'd15;
   localparam logic [4:0] POS_DATA       = 5'd17;
   localparam logic [4:0] TAIL_READ      = 5'd14;
   localparam logic [4:0] TAIL_WRITE     = 5'd25;

   // Response layout
   localparam int HDR_LEN     = 6;
   localparam int VALUE_FIRST = 17;
   localparam int VALUE_LAST  = 24;

   typedef struct packed {
      logic       busy;
      logic [7:0] data;
      logic       last;
   } tx_beat_type;

   typedef struct packed {
      logic        done;
      logic [1:0]  status;
      logic [31:0] value;
   } rx_done_type;

   function automatic logic [7:0] hex_lower(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = CH_ZERO + {4'd0, nib};
      end else begin
         ch = 8'h57 + {4'd0, nib};
      end
      return ch;
   endfunction

   function automatic logic [7:0] hex_upper(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = CH_ZERO + {4'd0, nib};
      end else begin
         ch = 8'h37 + {4'd0, nib};
      end
      return ch;
   endfunction

   // Returns {is_hex, digit value}
   function automatic logic [4:0] hex_digit(input logic [7:0] ch);
      logic [4:0] res;
      res = 5'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         res = {1'b1, 4'(ch - 8'h30)};
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         res = {1'b1, 4'(ch - 8'h57)};
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         res = {1'b1, 4'(ch - 8'h37)};
      end
      return res;
   endfunction

endpackage

// File: rtl/core/racodec_tx.sv
module racodec_tx
   import racodec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load_valid,
   input  logic        load_write,
   input  logic [31:0] load_addr,
   input  logic [31:0] load_data,
   input  logic        advance,
   output tx_beat_type tx_out
);

   logic        busy_ff, busy_in;
   logic [4:0]  idx_ff, idx_in;
   logic        write_ff, write_in;
   logic [31:0] addr_sh_ff, addr_sh_in;
   logic [31:0] data_sh_ff, data_sh_in;
   logic [7:0]  cs_ff, cs_in;

   logic [7:0]  beat_data;
   logic        beat_last;
   logic        shift_addr;
   logic        shift_data;
   logic [4:0]  tail_pos;
   logic [4:0]  tail_rel;

   // Checksum of the frame body, worked out while loading
   always_comb begin
      cs_in = load_write ? CMD_XOR_WRITE : CMD_XOR_READ;
      for (int k = 0; k < 8; k++) begin
         cs_in = cs_in ^ hex_lower(load_addr[4*k +: 4]);
         if (load_write) begin
            cs_in = cs_in ^ hex_lower(load_data[4*k +: 4]);
         end
      end
      if (load_write) begin
         cs_in = cs_in ^ SEP_XOR;
      end
   end

   // Byte at the current frame position
   always_comb begin
      tail_pos   = write_ff ? TAIL_WRITE : TAIL_READ;
      tail_rel   = idx_ff - tail_pos;
      beat_data  = CH_X;
      beat_last  = 1'b0;
      shift_addr = 1'b0;
      shift_data = 1'b0;
      if (idx_ff < POS_ADDR) begin
         case (idx_ff[2:0])
            3'd0:    beat_data = CH_DOLLAR;
            3'd1:    beat_data = write_ff ? CH_W : CH_R;
            3'd2:    beat_data = CH_C;
            3'd3:    beat_data = CH_COMMA;
            3'd4:    beat_data = CH_ZERO;
            default: beat_data = CH_X;
         endcase
      end else if (idx_ff < POS_ADDR_END) begin
         beat_data  = hex_lower(addr_sh_ff[31:28]);
         shift_addr = 1'b1;
      end else if (idx_ff < tail_pos) begin
         if (idx_ff == POS_SEP_COMMA) begin
            beat_data = CH_COMMA;
         end else if (idx_ff == POS_SEP_ZERO) begin
            beat_data = CH_ZERO;
         end else if (idx_ff < POS_DATA) begin
            beat_data = CH_X;
         end else begin
            beat_data  = hex_lower(data_sh_ff[31:28]);
            shift_data = 1'b1;
         end
      end else begin
         case (tail_rel[2:0])
            3'd0:    beat_data = CH_STAR;
            3'd1:    beat_data = hex_upper(cs_ff[7:4]);
            3'd2:    beat_data = hex_upper(cs_ff[3:0]);
            3'd3:    beat_data = CH_CR;
            default: beat_data = CH_LF;
         endcase
         beat_last = (tail_rel == 5'd4);
      end
   end

   always_comb begin
      busy_in    = busy_ff;
      idx_in     = idx_ff;
      write_in   = write_ff;
      addr_sh_in = addr_sh_ff;
      data_sh_in = data_sh_ff;
      if (load_valid) begin
         busy_in    = 1'b1;
         idx_in     = 5'd0;
         write_in   = load_write;
         addr_sh_in = load_addr;
         data_sh_in = load_data;
      end else if (advance && busy_ff) begin
         idx_in = idx_ff + 5'd1;
         if (shift_addr) begin
            addr_sh_in = {addr_sh_ff[27:0], 4'd0};
         end
         if (shift_data) begin
            data_sh_in = {data_sh_ff[27:0], 4'd0};
         end
         if (beat_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      write_ff   <= write_in;
      addr_sh_ff <= addr_sh_in;
      data_sh_ff <= data_sh_in;
      if (load_valid) begin
         cs_ff <= cs_in;
      end
   end

   assign tx_out.busy = busy_ff;
   assign tx_out.data = beat_data;
   assign tx_out.last = beat_last;

endmodule

// File: rtl/core/racodec_rx.sv
module racodec_rx
   import racodec_pkg::*;
#(
   parameter int MAX_FRAME = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  logic        cmd_write,
   input  logic        byte_valid,
   input  logic [7:0]  rx_byte,
   output rx_done_type rx_out
);

   localparam int PW = $clog2(MAX_FRAME + 1);

   typedef enum logic [2:0] {
      PEND_NONE  = 3'b001,
      PEND_READ  = 3'b010,
      PEND_WRITE = 3'b100
   } pend_type;

   pend_type    pend_ff, pend_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]  xor_ff, xor_in;
   logic        star_ff, star_in;
   logic        hok_ff, hok_in;
   logic [7:0]  tail_ff [4];
   logic [7:0]  tail_in [4];
   logic [31:0] acc_ff, acc_in;
   logic        stop_ff, stop_in;

   logic        pending;
   logic        is_lf;
   logic        room;
   logic        take;
   logic        done;
   logic [7:0]  hdr_char;
   logic [4:0]  digit;
   logic [1:0]  status;

   assign pending = (pend_ff != PEND_NONE);
   assign is_lf   = (rx_byte == CH_LF);
   assign room    = (pos_ff < PW'(MAX_FRAME));
   assign take    = byte_valid && pending && (is_lf || room);
   assign done    = byte_valid && pending && is_lf;
   assign digit   = hex_digit(rx_byte);

   always_comb begin
      case (pos_ff[2:0])
         3'd0:    hdr_char = CH_DOLLAR;
         3'd1:    hdr_char = (pend_ff == PEND_WRITE) ? CH_W : CH_R;
         3'd2:    hdr_char = CH_R;
         3'd3:    hdr_char = CH_COMMA;
         3'd4:    hdr_char = CH_ZERO;
         default: hdr_char = CH_X;
      endcase
   end

   // Effect of taking the current byte
   always_comb begin
      hok_in  = hok_ff;
      star_in = star_ff;
      xor_in  = xor_ff;
      acc_in  = acc_ff;
      stop_in = stop_ff;
      pos_in  = pos_ff;
      if (pos_ff < PW'(HDR_LEN) && rx_byte != hdr_char) begin
         hok_in = 1'b0;
      end
      if (pos_ff != '0 && !star_ff) begin
         if (rx_byte == CH_STAR) begin
            star_in = 1'b1;
         end else begin
            xor_in = xor_ff ^ rx_byte;
         end
      end
      tail_in[0] = tail_ff[1];
      tail_in[1] = tail_ff[2];
      tail_in[2] = tail_ff[3];
      tail_in[3] = rx_byte;
      if (pos_ff >= PW'(VALUE_FIRST) && pos_ff <= PW'(VALUE_LAST) && !stop_ff) begin
         if (!digit[4]) begin
            stop_in = 1'b1;
         end else begin
            acc_in = {acc_ff[27:0], digit[3:0]};
         end
      end
      if (room) begin
         pos_in = pos_ff + PW'(1);
      end
   end

   // Completion check on the state as it stands after the LF
   always_comb begin
      if (!hok_in) begin
         status = STATUS_HEADER;
      end else if (pos_in < PW'(4) ||
                   tail_in[0] != hex_upper(xor_in[7:4]) ||
                   tail_in[1] != hex_upper(xor_in[3:0]) ||
                   tail_in[2] != CH_CR || tail_in[3] != CH_LF) begin
         status = STATUS_CHECKSUM;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (cmd_valid) begin
         pend_in = cmd_write ? PEND_WRITE : PEND_READ;
      end else if (done) begin
         pend_in = PEND_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= PEND_NONE;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd_valid || done) begin
         pos_ff  <= '0;
         xor_ff  <= 8'd0;
         star_ff <= 1'b0;
         hok_ff  <= 1'b1;
         acc_ff  <= 32'd0;
         stop_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            tail_ff[k] <= 8'd0;
         end
      end else if (take) begin
         pos_ff  <= pos_in;
         xor_ff  <= xor_in;
         star_ff <= star_in;
         hok_ff  <= hok_in;
         acc_ff  <= acc_in;
         stop_ff <= stop_in;
         for (int k = 0; k < 4; k++) begin
            tail_ff[k] <= tail_in[k];
         end
      end
   end

   assign rx_out.done   = done;
   assign rx_out.status = status;
   assign rx_out.value  = (status == STATUS_OK && pend_ff == PEND_READ) ? acc_in : 32'd0;

endmodule

// File: rtl/core/register_access_frame_codec.sv
// Register access frame codec. Each req_ beat is a read command, a write
// command or one received response character (req_tuser selects which).
// A command beat becomes an ASCII frame on the rsp_ side, one character per
// beat: 19 beats for a read ("$RC,0x" + address + "*" + checksum + CR LF),
// 30 beats for a write (",0x" + data after the address), tlast on the LF.
// The frame streams out of a byte-position counter at one beat per cycle
// while the sink accepts, and req_tready stays low from the command beat
// until the final frame beat has entered the output register. Response
// characters are checked against the pending header and the running XOR
// checksum as they arrive, and an LF gives one completion beat (rsp_tuser
// high) with status and, for a good read, the value parsed from positions
// 17 to 24. A completion is valid in the cycle after its LF beat; a command
// beat is registered in the frame counter first and its first frame beat
// then enters the output register once it is free; both results leave from
// a single output register. A new input beat is taken only while that
// register is empty or draining in the same cycle, so a stalled sink holds
// the input off. Response characters with nothing pending, and beats with
// the reserved kind, are accepted and dropped. A new command discards any
// pending transaction. MAX_FRAME caps the response length counted;
// characters beyond it other than LF are dropped.
module register_access_frame_codec
   import racodec_pkg::*;
#(
   parameter int MAX_FRAME = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] reg_address, [63:32] write_value, [71:64] rx_byte
   input  logic [71:0] req_tdata,
   // [1:0] opcode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] tx_byte, [9:8] status, [41:10] read_value, [47:42] zero
   output logic [47:0] rsp_tdata,
   // [0] result_kind
   output logic        rsp_tuser,
   // frame_last
   output logic        rsp_tlast
);

   tx_beat_type tx_out;
   rx_done_type rx_out;

   logic        out_free;
   logic        req_fire;
   logic        cmd_fire;
   logic        rx_fire;
   logic        tx_adv;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_last_ff;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_value_ff;

   // Output slot is free when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !tx_out.busy && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign cmd_fire   = req_fire && (req_tuser == OP_READ || req_tuser == OP_WRITE);
   assign rx_fire    = req_fire && (req_tuser == OP_RX);
   assign tx_adv     = tx_out.busy && out_free;

   racodec_tx u_tx (
      .clock      (clock),
      .reset      (reset),
      .load_valid (cmd_fire),
      .load_write (req_tuser == OP_WRITE),
      .load_addr  (req_tdata[31:0]),
      .load_data  (req_tdata[63:32]),
      .advance    (tx_adv),
      .tx_out     (tx_out)
   );

   racodec_rx #(
      .MAX_FRAME (MAX_FRAME)
   ) u_rx (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_fire),
      .cmd_write  (req_tuser == OP_WRITE),
      .byte_valid (rx_fire),
      .rx_byte    (req_tdata[71:64]),
      .rx_out     (rx_out)
   );

   // Load a frame beat or a completion; otherwise drop the beat once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (tx_adv || rx_out.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tx_adv) begin
         rsp_kind_ff   <= KIND_TX;
         rsp_byte_ff   <= tx_out.data;
         rsp_last_ff   <= tx_out.last;
         rsp_status_ff <= STATUS_OK;
         rsp_value_ff  <= 32'd0;
      end else if (rx_out.done) begin
         rsp_kind_ff   <= KIND_DONE;
         rsp_byte_ff   <= 8'd0;
         rsp_last_ff   <= 1'b0;
         rsp_status_ff <= rx_out.status;
         rsp_value_ff  <= rx_out.value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'd0, rsp_value_ff, rsp_status_ff, rsp_byte_ff};

`ifndef SYNTH
   a_no_accept_while_framing: assert property (@(posedge clock) disable iff (reset)
      tx_out.busy |-> !req_tready)
      else $error("input accepted while a command frame is streaming");

   a_frame_end_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> !tx_out.busy)
      else $error("frame end shown while the frame counter is still busy");

   a_tx_beat_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_TX) |-> (rsp_tdata[41:8] == 34'd0))
      else $error("frame beat carries status or value bits");

   a_done_beat_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_DONE) |-> (!rsp_tlast && rsp_tdata[7:0] == 8'd0))
      else $error("completion beat carries frame bits");

   a_value_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[9:8] != STATUS_OK) |-> (rsp_tdata[41:10] == 32'd0))
      else $error("value reported with a failing status");
`endif

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import racodec_pkg::*;

   localparam int FRAME_CAP       = 64;      // response length counted by the codec
   localparam int RANDOM_ITEMS    = 220;     // counted items in the random part
   localparam int CALM_TAIL_ITEMS = 40;      // final stretch with no idling on either side
   localparam int CYCLE_LIMIT     = 500000;  // several times the slowest correct run
   localparam int DRAIN_CYCLES    = 24;      // settle time once nothing is outstanding
   localparam logic [1:0] OP_RESERVED = 2'd3;

   // ASCII helpers not in the package
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_F  = 8'h46;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_F  = 8'h66;
   localparam logic [7:0] CH_NUL      = 8'h00;

   typedef enum logic [1:0] {PEND_NONE, PEND_READ, PEND_WRITE} pending_type;

   // Shapes of a generated response frame
   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_HEADER,
      FRAME_BAD_SUM,
      FRAME_BAD_BOTH,
      FRAME_NO_STAR,
      FRAME_SHORT_VALUE,
      FRAME_ZERO_BYTE,
      FRAME_OVERLONG,
      FRAME_NOISE,
      FRAME_KINDS
   } frame_shape_type;

   // One result beat as the codec should present it
   typedef struct packed {
      logic        kind;
      logic [7:0]  char_out;
      logic        last;
      logic [1:0]  status;
      logic [31:0] value;
   } rsp_beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;     // [31:0] reg_address, [63:32] write_value, [71:64] rx_byte
   logic [1:0]  req_tuser  = OP_READ; // [1:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;           // [7:0] tx_byte, [9:8] status, [41:10] read_value
   logic        rsp_tuser;           // [0] result_kind
   logic        rsp_tlast;

   // Frame and response tracking for the codec
   pending_type pending      = PEND_NONE;
   int unsigned rx_count     = 0;
   logic [7:0]  rx_sum       = '0;
   bit          star_hit     = 1'b0;
   bit          header_good  = 1'b1;
   logic [7:0]  last_four[4] = '{default: 8'h00};
   logic [31:0] value_acc    = '0;
   bit          value_ended  = 1'b0;

   rsp_beat_type expected_beats[$];

   // Pacing and bookkeeping
   bit          calm_tail    = 1'b0;
   bit          sender_calm  = 1'b0;
   bit          sink_calm    = 1'b0;
   int          stall_left   = 0;
   int          calm_after   = 32'h7fff_ffff;
   int          items_sent   = 0;
   int          frames_sent  = 0;
   int          beats_checked = 0;
   int          done_ok      = 0;
   int          done_header  = 0;
   int          done_sum     = 0;
   int          errors       = 0;
   int          cycle_count  = 0;

   always #4 clock = ~clock;

   register_access_frame_codec u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // ------------------------------------------------------------------
   // Character helpers
   // ------------------------------------------------------------------

   function automatic logic [7:0] nibble_char(input logic [3:0] nib, input bit upper);
      if (nib < 4'd10) begin
         return CH_ZERO + 8'(nib);
      end
      return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(nib) - 8'd10;
   endfunction

   // Value of a hex digit in either case, -1 for anything else
   function automatic int digit_of(input logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) begin
         return int'(c) - int'(CH_ZERO);
      end
      if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
         return int'(c) - int'(CH_LOWER_A) + 10;
      end
      if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
         return int'(c) - int'(CH_UPPER_A) + 10;
      end
      return -1;
   endfunction

   // Any byte but LF, so a generated body never ends early
   function automatic logic [7:0] random_char();
      logic [7:0] c;
      do c = 8'($urandom); while (c == CH_LF);
      return c;
   endfunction

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   function automatic void clear_receive();
      rx_count    = 0;
      rx_sum      = '0;
      star_hit    = 1'b0;
      header_good = 1'b1;
      last_four   = '{default: 8'h00};
      value_acc   = '0;
      value_ended = 1'b0;
   endfunction

   // Build the whole command frame and queue one beat per character; the
   // new command drops whatever response was in progress.
   function automatic void predict_command(input bit is_write, input logic [31:0] addr,
                                           input logic [31:0] data);
      logic [7:0]   frame[$];
      logic [7:0]   sum;
      rsp_beat_type beat;
      frame = {CH_DOLLAR, is_write ? CH_W : CH_R, CH_C, CH_COMMA, CH_ZERO, CH_X};
      for (int i = 7; i >= 0; i--) frame.push_back(nibble_char(addr[4*i +: 4], 1'b0));
      if (is_write) begin
         frame.push_back(CH_COMMA);
         frame.push_back(CH_ZERO);
         frame.push_back(CH_X);
         for (int i = 7; i >= 0; i--) frame.push_back(nibble_char(data[4*i +: 4], 1'b0));
      end
      // checksum skips the leading dollar and stops short of the star
      sum = '0;
      for (int i = 1; i < frame.size(); i++) sum ^= frame[i];
      frame.push_back(CH_STAR);
      frame.push_back(nibble_char(sum[7:4], 1'b1));
      frame.push_back(nibble_char(sum[3:0], 1'b1));
      frame.push_back(CH_CR);
      frame.push_back(CH_LF);
      foreach (frame[i]) begin
         beat          = '0;
         beat.kind     = KIND_TX;
         beat.char_out = frame[i];
         beat.last     = (i == frame.size() - 1);
         expected_beats.push_back(beat);
      end
      clear_receive();
      pending = is_write ? PEND_WRITE : PEND_READ;
   endfunction

   // Fold one response character into header, checksum, tail and value tracking
   function automatic void absorb_char(input logic [7:0] c);
      logic [7:0] hdr[6];
      int         d;
      hdr = '{CH_DOLLAR, (pending == PEND_WRITE) ? CH_W : CH_R, CH_R, CH_COMMA, CH_ZERO, CH_X};
      if (rx_count < 6 && c != hdr[rx_count]) header_good = 1'b0;
      if (rx_count >= 1 && !star_hit) begin
         if (c == CH_STAR) star_hit = 1'b1;
         else rx_sum ^= c;
      end
      last_four = '{last_four[1], last_four[2], last_four[3], c};
      if (rx_count >= 17 && rx_count <= 24 && !value_ended) begin
         d = digit_of(c);
         if (d < 0) value_ended = 1'b1;
         else value_acc = {value_acc[27:0], 4'(d)};
      end
      if (rx_count < FRAME_CAP) rx_count++;
   endfunction

   function automatic void predict_rx(input logic [7:0] c);
      rsp_beat_type beat;
      // nothing pending: drop silently
      if (pending == PEND_NONE) return;
      if (c != CH_LF) begin
         if (rx_count < FRAME_CAP) absorb_char(c);
         return;
      end
      absorb_char(c);
      beat      = '0;
      beat.kind = KIND_DONE;
      // a header fault wins over a checksum fault
      if (!header_good) begin
         beat.status = STATUS_HEADER;
      end else if (rx_count < 4 ||
                   last_four[0] != nibble_char(rx_sum[7:4], 1'b1) ||
                   last_four[1] != nibble_char(rx_sum[3:0], 1'b1) ||
                   last_four[2] != CH_CR || last_four[3] != CH_LF) begin
         beat.status = STATUS_CHECKSUM;
      end else begin
         beat.status = STATUS_OK;
         if (pending == PEND_READ) beat.value = value_acc;
      end
      expected_beats.push_back(beat);
      pending = PEND_NONE;
      clear_receive();
   endfunction

   // ------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------

   // Present one beat on req_ and hold it until accepted, then predict it.
   // Valid stays high afterwards; a drain, or a next call that idles first, lowers it.
   task automatic send_item(input logic [1:0] op, input logic [31:0] addr,
                            input logic [31:0] data, input logic [7:0] ch);
      int gap;
      if (items_sent >= calm_after) calm_tail = 1'b1;
      gap = 0;
      if (!calm_tail && !sender_calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
      if ($urandom_range(0, 60) == 0) sender_calm = !sender_calm;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {ch, data, addr};
      do @(posedge clock); while (req_tready !== 1'b1);
      // beats the codec only drops don't count toward the item budget
      if (!(op == OP_RESERVED || (op == OP_RX && pending == PEND_NONE))) items_sent++;
      case (op)
         OP_READ: begin
            predict_command(1'b0, addr, data);
            frames_sent++;
         end
         OP_WRITE: begin
            predict_command(1'b1, addr, data);
            frames_sent++;
         end
         OP_RX: begin
            predict_rx(ch);
         end
         default: begin
         end
      endcase
   endtask

   // Drop valid and hold off until every predicted beat has been seen
   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
   endtask

   // Generate a response frame of the given shape and feed it character by
   // character; it always ends with LF so the transaction closes.
   task automatic send_response(input pending_type kind, input frame_shape_type shape);
      logic [7:0] resp[$];
      logic [7:0] sum;
      logic [7:0] stop_char;
      int         ndig;
      if (shape == FRAME_NOISE) begin
         repeat ($urandom_range(1, 20)) resp.push_back(random_char());
      end else begin
         resp = {CH_DOLLAR, (kind == PEND_WRITE) ? CH_W : CH_R, CH_R, CH_COMMA, CH_ZERO, CH_X};
         if (shape == FRAME_BAD_HEADER || shape == FRAME_BAD_BOTH) begin
            resp[$urandom_range(0, 5)] ^= 8'h01 << $urandom_range(0, 7);
         end
         // echoed address, then ",0x" and the value in mixed case
         repeat (8) resp.push_back(nibble_char(4'($urandom), 1'($urandom)));
         resp.push_back(CH_COMMA);
         resp.push_back(CH_ZERO);
         resp.push_back(CH_X);
         ndig = (shape == FRAME_SHORT_VALUE) ? $urandom_range(0, 7) : 8;
         repeat (ndig) resp.push_back(nibble_char(4'($urandom), 1'($urandom)));
         if (shape == FRAME_SHORT_VALUE) begin
            // end the value early; digits after the stop must be ignored
            do stop_char = random_char(); while (digit_of(stop_char) >= 0);
            resp.push_back(stop_char);
            repeat (2) resp.push_back(nibble_char(4'($urandom), 1'($urandom)));
         end
         if (shape == FRAME_ZERO_BYTE) resp.insert($urandom_range(6, resp.size() - 1), CH_NUL);
         if (shape == FRAME_OVERLONG) begin
            repeat ($urandom_range(50, 70)) resp.push_back(random_char());
         end
         sum = '0;
         for (int i = 1; i < resp.size(); i++) sum ^= resp[i];
         if (shape == FRAME_BAD_SUM || shape == FRAME_BAD_BOTH) sum ^= 8'h01 << $urandom_range(0, 7);
         if (shape != FRAME_NO_STAR) resp.push_back(CH_STAR);
         resp.push_back(nibble_char(sum[7:4], 1'b1));
         resp.push_back(nibble_char(sum[3:0], 1'b1));
         resp.push_back(CH_CR);
      end
      resp.push_back(CH_LF);
      foreach (resp[i]) send_item(OP_RX, $urandom, $urandom, resp[i]);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Command frames at the address and data extremes, the reserved kind,
   // and response characters with nothing pending
   task automatic test_command_extremes();
      send_item(OP_READ,  32'h0000_0000, 32'h0000_0000, 8'h00);
      send_item(OP_READ,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
      send_item(OP_WRITE, 32'h0000_0000, 32'hFFFF_FFFF, 8'h00);
      send_item(OP_WRITE, 32'hFFFF_FFFF, 32'h0000_0000, 8'hFF);
      send_item(OP_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, CH_LF);
      // bare LF closes the pending write with a header fault
      send_item(OP_RX, 32'h0000_0000, 32'h0000_0000, CH_LF);
      send_item(OP_RX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00);
      send_item(OP_RX, 32'h0000_0000, 32'h0000_0000, 8'hFF);
      send_item(OP_RX, 32'h0000_0000, 32'h0000_0000, CH_LF);
   endtask

   // Truncated responses, and a new command replacing a pending one
   task automatic test_truncated_responses();
      send_item(OP_READ, $urandom, $urandom, 8'h00);
      send_item(OP_RX, $urandom, $urandom, CH_DOLLAR);
      send_item(OP_RX, $urandom, $urandom, CH_R);
      send_item(OP_RX, $urandom, $urandom, CH_R);
      send_item(OP_RX, $urandom, $urandom, CH_LF);
      send_item(OP_WRITE, $urandom, $urandom, 8'h00);
      send_item(OP_READ, $urandom, $urandom, 8'h00);
      // write header against the read that replaced the write
      send_item(OP_RX, $urandom, $urandom, CH_DOLLAR);
      send_item(OP_RX, $urandom, $urandom, CH_W);
      send_item(OP_RX, $urandom, $urandom, CH_LF);
   endtask

   // Command plus response transactions: every frame shape once first, then
   // mostly well-formed frames with random content and some broken ones
   task automatic test_random_transactions();
      int              start_count;
      int              round;
      pending_type     kind;
      frame_shape_type shape;
      start_count = items_sent;
      calm_after  = start_count + RANDOM_ITEMS - CALM_TAIL_ITEMS;
      round       = 0;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 1) ? PEND_WRITE : PEND_READ;
         if (round < FRAME_KINDS) begin
            shape = frame_shape_type'(round);
         end else if ($urandom_range(0, 2) == 0) begin
            shape = frame_shape_type'($urandom_range(0, FRAME_KINDS - 1));
         end else begin
            shape = FRAME_GOOD;
         end
         // stray beats while idle: all dropped by the codec
         repeat ($urandom_range(0, 2)) begin
            send_item($urandom_range(0, 1) ? OP_RESERVED : OP_RX, $urandom, $urandom,
                      8'($urandom));
         end
         send_item((kind == PEND_WRITE) ? OP_WRITE : OP_READ, $urandom, $urandom, 8'($urandom));
         // now and then reissue before any response comes back
         if ($urandom_range(0, 9) == 0) begin
            send_item((kind == PEND_WRITE) ? OP_WRITE : OP_READ, $urandom, $urandom,
                      8'($urandom));
         end
         send_response(kind, shape);
         // hold the sender once until the output side has fully caught up
         if (round == 4) wait_for_drain();
         round++;
      end
   endtask

   // ------------------------------------------------------------------
   // Output side
   // ------------------------------------------------------------------

   // Stall the sink in random bursts, with calm stretches
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm_tail && !sink_calm && $urandom_range(0, 6) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
      if ($urandom_range(0, 199) == 0) sink_calm <= !sink_calm;
   end

   task automatic compare_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
      end
   endtask

   // Match each accepted result beat against the oldest prediction
   always @(posedge clock) begin : check_results
      rsp_beat_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat: expected none, got tuser=%0b tdata=0x%0h tlast=%0b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
         end else begin
            want = expected_beats.pop_front();
            beats_checked++;
            compare_field("result_kind", 32'(want.kind), 32'(rsp_tuser));
            compare_field("tx_byte", 32'(want.char_out), 32'(rsp_tdata[7:0]));
            compare_field("frame_last", 32'(want.last), 32'(rsp_tlast));
            compare_field("status", 32'(want.status), 32'(rsp_tdata[9:8]));
            compare_field("read_value", want.value, rsp_tdata[41:10]);
            compare_field("tdata padding", 32'd0, 32'(rsp_tdata[47:42]));
            if (want.kind == KIND_DONE) begin
               case (want.status)
                  STATUS_OK:       done_ok++;
                  STATUS_HEADER:   done_header++;
                  STATUS_CHECKSUM: done_sum++;
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d result beats still outstanding", $time,
                  expected_beats.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_command_extremes();
      test_truncated_responses();
      test_random_transactions();

      // drop valid, wait out every prediction, then let the output settle
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d command frames and %0d counted input beats.",
               frames_sent, items_sent);
      $display("Checked %0d result beats; completions: %0d ok, %0d header, %0d checksum.",
               beats_checked, done_ok, done_header, done_sum);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
